@@ hdl/ams_pkg.sv @@
// Package: opcodes, status codes and sequencer state for the accumulator machine.
package ams_pkg;

   localparam int unsigned WORD_W = 32;

   typedef enum logic [2:0] {
      ST_LOADED  = 3'd0,
      ST_EXEC    = 3'd1,
      ST_OUTPUT  = 3'd2,
      ST_STOPPED = 3'd3,
      ST_PASTEND = 3'd4,
      ST_ERROR   = 3'd5
   } status_type;

   localparam logic [31:0] OP_ADD    = 32'd1;
   localparam logic [31:0] OP_SUB    = 32'd2;
   localparam logic [31:0] OP_MULT   = 32'd3;
   localparam logic [31:0] OP_DIV    = 32'd4;
   localparam logic [31:0] OP_JMP    = 32'd5;
   localparam logic [31:0] OP_JMPN   = 32'd6;
   localparam logic [31:0] OP_JMPP   = 32'd7;
   localparam logic [31:0] OP_JMPZ   = 32'd8;
   localparam logic [31:0] OP_COPY   = 32'd9;
   localparam logic [31:0] OP_LOAD   = 32'd10;
   localparam logic [31:0] OP_STORE  = 32'd11;
   localparam logic [31:0] OP_INPUT  = 32'd12;
   localparam logic [31:0] OP_OUTPUT = 32'd13;
   localparam logic [31:0] OP_STOP   = 32'd14;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FETCH_OP,
      S_DECODE,
      S_FETCH_A,
      S_GOT_A,
      S_FETCH_B,
      S_GOT_B,
      S_READ_DATA,
      S_EXECUTE,
      S_MUL_WAIT,
      S_DIV_WAIT,
      S_RESPOND
   } seq_state_type;

   // memory request from sequencer to memory
   typedef struct packed {
      logic        rd;
      logic        wr;
      logic [31:0] wdata;
   } mem_ctl_type;

endpackage

@@ hdl/ams_mem.sv @@
// Word memory: one write port, one registered read port.
module ams_mem
   import ams_pkg::*;
#(
   parameter int unsigned ADDR_W = 8
) (
   input  logic              clock,
   input  logic [ADDR_W-1:0] addr,
   input  mem_ctl_type       ctl,
   output logic [31:0]       rdata
);

   logic [31:0] mem_ff [2**ADDR_W];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem_ff[addr] <= ctl.wdata;
      end
      if (ctl.rd) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/ams_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module ams_div
   import ams_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend[31] ? (32'd0 - dividend) : dividend;
         dvs_in  = divisor[31] ? (32'd0 - divisor) : divisor;
         neg_in  = dividend[31] ^ divisor[31];
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;

endmodule

@@ hdl/ams_seq.sv @@
// Instruction sequencer: program loads, and per step fetch, decode, operand reads, execute and write back.
module ams_seq
   import ams_pkg::*;
#(
   parameter int unsigned MEM_DEPTH = 256,
   parameter int unsigned ADDR_W    = 8,
   parameter int unsigned LEN_W     = 9
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_mode,
   input  logic [31:0]       req_value,
   output logic              busy,
   output logic [ADDR_W-1:0] mem_addr,
   output mem_ctl_type       mem_ctl,
   input  logic [31:0]       mem_rdata,
   output logic              div_start,
   output logic [31:0]       div_dividend,
   output logic [31:0]       div_divisor,
   input  logic              div_done,
   input  logic [31:0]       div_quotient,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic [31:0]       rsp_out_value,
   output logic [31:0]       rsp_acc_value,
   output logic [8:0]        rsp_next_pc
);

   localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(MEM_DEPTH);

   seq_state_type state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] pc_ff, pc_in;
   logic [31:0]      acc_ff, acc_in;
   logic [2:0]       halt_ff, halt_in;
   logic [31:0]      val_ff, val_in;
   logic [31:0]      op_ff, op_in;
   logic [31:0]      opa_ff, opa_in;
   logic [31:0]      opb_ff, opb_in;
   logic [31:0]      dat_ff, dat_in;
   logic [31:0]      prod_ff, prod_in;
   logic [2:0]       st_ff, st_in;
   logic [31:0]      outv_ff, outv_in;
   logic             rsp_ff, rsp_in;

   logic [LEN_W:0]   pc1, pc2, pc3;
   logic             a_ok, b_ok, tgt_ok, is_jcond, take, known;
   logic             accept;

   assign accept = start && !busy;
   assign pc1 = {1'b0, pc_ff} + 1'b1;
   assign pc2 = {1'b0, pc_ff} + 2'd2;
   assign pc3 = {1'b0, pc_ff} + 2'd3;
   assign a_ok   = !opa_ff[31] && (opa_ff < 32'(len_ff));
   assign b_ok   = !opb_ff[31] && (opb_ff < 32'(len_ff));
   assign tgt_ok = !opa_ff[31] && (opa_ff <= 32'(len_ff));
   assign known  = (op_ff >= OP_ADD) && (op_ff <= OP_STOP);
   assign is_jcond = (op_ff >= OP_JMPN) && (op_ff <= OP_JMPZ);
   always_comb begin
      take = 1'b1;
      if (op_ff == OP_JMPN) begin
         take = acc_ff[31];
      end else if (op_ff == OP_JMPP) begin
         take = !acc_ff[31] && (acc_ff != '0);
      end else if (op_ff == OP_JMPZ) begin
         take = (acc_ff == '0);
      end
   end

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      pc_in    = pc_ff;
      acc_in   = acc_ff;
      halt_in  = halt_ff;
      val_in   = val_ff;
      op_in    = op_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      dat_in   = dat_ff;
      prod_in  = prod_ff;
      st_in    = st_ff;
      outv_in  = outv_ff;
      rsp_in   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in  = req_value;
               outv_in = '0;
               if (!req_mode) begin
                  if (len_ff >= DEPTH_L) begin
                     halt_in = ST_ERROR;
                     st_in   = ST_ERROR;
                  end else begin
                     len_in = len_ff + 1'b1;
                     st_in  = ST_LOADED;
                  end
                  state_in = S_RESPOND;
               end else if (halt_ff != ST_LOADED) begin
                  st_in    = halt_ff;
                  state_in = S_RESPOND;
               end else if (pc_ff >= len_ff) begin
                  halt_in  = ST_PASTEND;
                  st_in    = ST_PASTEND;
                  state_in = S_RESPOND;
               end else begin
                  state_in = S_FETCH_OP;
               end
            end
         end
         S_FETCH_OP: state_in = S_DECODE;
         S_DECODE: begin
            op_in    = mem_rdata;
            state_in = S_FETCH_A;
            st_in    = ST_EXEC;
            if (mem_rdata == OP_STOP) begin
               halt_in  = ST_STOPPED;
               st_in    = ST_STOPPED;
               state_in = S_RESPOND;
            end else if (!((mem_rdata >= OP_ADD) && (mem_rdata <= OP_STOP))) begin
               pc_in    = pc1[LEN_W-1:0];
               state_in = S_RESPOND;
            end
         end
         S_FETCH_A: begin
            // untaken branches respond without using the operand read
            if (is_jcond && !take) begin
               pc_in    = (pc2 > {1'b0, len_ff}) ? len_ff : pc2[LEN_W-1:0];
               state_in = S_RESPOND;
            end else if (pc1 >= {1'b0, len_ff}) begin
               halt_in  = ST_ERROR;
               st_in    = ST_ERROR;
               state_in = S_RESPOND;
            end else begin
               state_in = S_GOT_A;
            end
         end
         S_GOT_A: begin
            opa_in = mem_rdata;
            if (op_ff >= OP_JMP && op_ff <= OP_JMPZ) begin
               state_in = S_RESPOND;
               if (!mem_rdata[31] && mem_rdata <= 32'(len_ff)) begin
                  pc_in = mem_rdata[LEN_W-1:0];
               end else begin
                  halt_in = ST_ERROR;
                  st_in   = ST_ERROR;
               end
            end else if (op_ff == OP_COPY) begin
               state_in = S_FETCH_B;
            end else begin
               state_in = S_READ_DATA;
            end
         end
         S_FETCH_B: begin
            if (pc2 >= {1'b0, len_ff}) begin
               halt_in  = ST_ERROR;
               st_in    = ST_ERROR;
               state_in = S_RESPOND;
            end else begin
               state_in = S_GOT_B;
            end
         end
         S_GOT_B: begin
            opb_in   = mem_rdata;
            state_in = S_READ_DATA;
         end
         S_READ_DATA: begin
            if (!a_ok || (op_ff == OP_COPY && !b_ok)) begin
               halt_in  = ST_ERROR;
               st_in    = ST_ERROR;
               state_in = S_RESPOND;
            end else begin
               state_in = S_EXECUTE;
            end
         end
         S_EXECUTE: begin
            dat_in   = mem_rdata;
            state_in = S_RESPOND;
            if (op_ff == OP_COPY) begin
               pc_in = pc3[LEN_W-1:0];
            end else begin
               pc_in = pc2[LEN_W-1:0];
            end
            case (op_ff)
               OP_ADD:  acc_in = acc_ff + mem_rdata;
               OP_SUB:  acc_in = acc_ff - mem_rdata;
               OP_LOAD: acc_in = mem_rdata;
               OP_MULT: begin
                  prod_in  = acc_ff * mem_rdata;
                  pc_in    = pc_ff;
                  state_in = S_MUL_WAIT;
               end
               OP_DIV: begin
                  if (mem_rdata == '0) begin
                     halt_in = ST_ERROR;
                     st_in   = ST_ERROR;
                     pc_in   = pc_ff;
                  end else begin
                     pc_in    = pc_ff;
                     state_in = S_DIV_WAIT;
                  end
               end
               OP_OUTPUT: begin
                  outv_in = mem_rdata;
                  st_in   = ST_OUTPUT;
               end
               default: ;
            endcase
         end
         S_MUL_WAIT: begin
            acc_in   = prod_ff;
            pc_in    = pc2[LEN_W-1:0];
            state_in = S_RESPOND;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               acc_in   = div_quotient;
               pc_in    = pc2[LEN_W-1:0];
               state_in = S_RESPOND;
            end
         end
         S_RESPOND: begin
            rsp_in   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory port and divider control
   always_comb begin
      mem_addr      = pc_ff[ADDR_W-1:0];
      mem_ctl.rd    = 1'b0;
      mem_ctl.wr    = 1'b0;
      mem_ctl.wdata = acc_ff;
      div_start     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            // a step fetches the opcode at PC, a load appends at the length
            mem_addr      = req_mode ? pc_ff[ADDR_W-1:0] : len_ff[ADDR_W-1:0];
            mem_ctl.wdata = req_value;
            mem_ctl.wr    = accept && !req_mode && (len_ff < DEPTH_L);
            mem_ctl.rd    = accept && req_mode;
         end
         S_FETCH_A: begin
            mem_addr   = pc1[ADDR_W-1:0];
            mem_ctl.rd = 1'b1;
         end
         S_FETCH_B: begin
            mem_addr   = pc2[ADDR_W-1:0];
            mem_ctl.rd = 1'b1;
         end
         S_READ_DATA: begin
            mem_addr   = opa_ff[ADDR_W-1:0];
            mem_ctl.rd = a_ok && (op_ff != OP_COPY || b_ok);
         end
         S_EXECUTE: begin
            mem_addr = opa_ff[ADDR_W-1:0];
            if (op_ff == OP_COPY) begin
               mem_addr      = opb_ff[ADDR_W-1:0];
               mem_ctl.wdata = mem_rdata;
               mem_ctl.wr    = 1'b1;
            end else if (op_ff == OP_STORE) begin
               mem_ctl.wr = 1'b1;
            end else if (op_ff == OP_INPUT) begin
               mem_ctl.wdata = val_ff;
               mem_ctl.wr    = 1'b1;
            end
            div_start = (op_ff == OP_DIV) && (mem_rdata != '0);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff   <= '0;
         pc_ff    <= '0;
         acc_ff   <= '0;
         halt_ff  <= ST_LOADED;
         rsp_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         pc_ff    <= pc_in;
         acc_ff   <= acc_in;
         halt_ff  <= halt_in;
         rsp_ff   <= rsp_in;
      end
      val_ff  <= val_in;
      op_ff   <= op_in;
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      dat_ff  <= dat_in;
      prod_ff <= prod_in;
      st_ff   <= st_in;
      outv_ff <= outv_in;
   end

   assign busy          = (state_ff != S_IDLE) || rsp_ff;
   assign div_dividend  = acc_ff;
   assign div_divisor   = dat_in;
   assign rsp_valid     = rsp_ff;
   assign rsp_status    = st_ff;
   assign rsp_out_value = outv_ff;
   assign rsp_acc_value = acc_ff;
   assign rsp_next_pc   = 9'(pc_ff);

   logic unused_known;
   assign unused_known = known ^ tgt_ok ^ dat_ff[0];

endmodule

@@ hdl/accumulator_machine_step_top.sv @@
// Top level: accumulator machine with word memory, sequencer and divider.
//   Channel | Ports                              | Handshake
//   req     | req_mode, req_value                | start && !busy
//   rsp     | rsp_status/out_value/acc_value/... | rsp_valid, one cycle
// The strobe follows the accept: a load or a halted or past-end step responds directly,
// STOP or unknown after decode, an untaken jump before and a taken jump after the target
// read, others after the data read, MULT after its product, DIV after the bit-serial divider;
// up to four reads and one write share one port. The next item is accepted after the strobe.
// Reset clears length, PC, accumulator and halt status; memory is not cleared.
// The receiver cannot stall; busy stays high until the strobe cycle has passed.
module accumulator_machine_step_top
   import ams_pkg::*;
#(
   parameter int unsigned MEM_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_out_value,
   output logic [31:0] rsp_acc_value,
   output logic [8:0]  rsp_next_pc
);

   localparam int unsigned ADDR_W = $clog2(MEM_DEPTH);
   localparam int unsigned LEN_W  = $clog2(MEM_DEPTH + 1);

   logic [ADDR_W-1:0] mem_addr;
   mem_ctl_type       mem_ctl;
   logic [31:0]       mem_rdata;
   logic              div_start, div_done;
   logic [31:0]       div_dividend, div_divisor, div_quotient;

   ams_mem #(.ADDR_W(ADDR_W)) u_mem (
      .clock (clock),
      .addr  (mem_addr),
      .ctl   (mem_ctl),
      .rdata (mem_rdata)
   );

   ams_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   ams_seq #(.MEM_DEPTH(MEM_DEPTH), .ADDR_W(ADDR_W), .LEN_W(LEN_W)) u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .busy          (busy),
      .mem_addr      (mem_addr),
      .mem_ctl       (mem_ctl),
      .mem_rdata     (mem_rdata),
      .div_start     (div_start),
      .div_dividend  (div_dividend),
      .div_divisor   (div_divisor),
      .div_done      (div_done),
      .div_quotient  (div_quotient),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_out_value (rsp_out_value),
      .rsp_acc_value (rsp_acc_value),
      .rsp_next_pc   (rsp_next_pc)
   );

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result strobe while not busy");
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OUTPUT |-> rsp_out_value == '0)
      else $error("output value without OUTPUT status");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted item did not raise busy");

endmodule
